@@ hw/rtl/char_lcd_4bit_interface_defines.svh @@
// Assertion macros for the character LCD interface checker.
// Needs i_clk, and i_rst_n for CLCD_ASSERT, in the scope of each use.
`ifndef CHAR_LCD_4BIT_INTERFACE_DEFINES_SVH
`define CHAR_LCD_4BIT_INTERFACE_DEFINES_SVH

// checked only out of reset
`define CLCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked in reset too
`define CLCD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/clcd_pkg.sv @@
// Shared types, codes and job builders for the character LCD interface.
// No dependencies.
`default_nettype none
package clcd_pkg;

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_CHAR   = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        JOB_WAIT   = 2'd0,
        JOB_NIBBLE = 2'd1,
        JOB_BYTE   = 2'd2
    } t_job_kind;

    localparam logic [15:0] E_PULSE_US    = 16'd5;
    localparam logic [15:0] SETTLE_US     = 16'd50;
    localparam logic [15:0] LONG_US       = 16'd5000;
    localparam logic [15:0] SHORT_NIB_US  = 16'd150;
    localparam logic [15:0] POWER_UP_US   = 16'd50000;
    localparam logic [7:0]  CHAR_NEWLINE  = 8'd10;
    localparam logic [7:0]  INS_SET_DDRAM = 8'h80;
    localparam logic [7:0]  INS_ROW1      = 8'h40;
    localparam logic [7:0]  INS_CLEAR     = 8'h01;
    localparam logic [5:0]  COL_MAX       = 6'd39;

    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int          INIT_STEPS    = 10;
    localparam int          STEP_W        = $clog2(INIT_STEPS);
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_STEPS - 1);

    // one queued job: a wait, one nibble or one byte
    typedef struct packed {
        t_job_kind   kind;
        logic        rs;
        logic [7:0]  value;
        logic [15:0] final_hold;  // hold of the closing E-low segment
        logic        last;
    } t_job;

    function automatic t_job byte_job(input logic rs, input logic [7:0] value,
                                      input logic [15:0] extra, input logic last);
        t_job j;
        j.kind       = JOB_BYTE;
        j.rs         = rs;
        j.value      = value;
        j.final_hold = E_PULSE_US + SETTLE_US + extra
                       + ((value <= 8'h03) ? LONG_US : 16'd0);
        j.last       = last;
        return j;
    endfunction

    function automatic t_job nibble_job(input logic [3:0] nib, input logic [15:0] extra);
        t_job j;
        j.kind       = JOB_NIBBLE;
        j.rs         = 1'b0;
        j.value      = {4'h0, nib};
        j.final_hold = E_PULSE_US + extra;
        j.last       = 1'b0;
        return j;
    endfunction

    // power-up sequence, one job per step
    function automatic t_job init_job(input logic [STEP_W-1:0] step);
        t_job j;
        unique case (step)
            STEP_W'(0): begin
                j.kind       = JOB_WAIT;
                j.rs         = 1'b0;
                j.value      = 8'h00;
                j.final_hold = POWER_UP_US;
                j.last       = 1'b0;
            end
            STEP_W'(1): j = nibble_job(4'h3, LONG_US);
            STEP_W'(2): j = nibble_job(4'h3, SHORT_NIB_US);
            STEP_W'(3): j = nibble_job(4'h3, SHORT_NIB_US);
            STEP_W'(4): j = nibble_job(4'h2, SHORT_NIB_US);
            STEP_W'(5): j = byte_job(1'b0, 8'h28, 16'd0, 1'b0);
            STEP_W'(6): j = byte_job(1'b0, 8'h08, 16'd0, 1'b0);
            STEP_W'(7): j = byte_job(1'b0, INS_CLEAR, LONG_US, 1'b0);
            STEP_W'(8): j = byte_job(1'b0, 8'h06, 16'd0, 1'b0);
            default:    j = byte_job(1'b0, 8'h0C, 16'd0, 1'b1);
        endcase
        return j;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/clcd_front.sv @@
// Request intake: turns each request into byte, nibble and wait jobs.
// Depends on clcd_pkg.
`default_nettype none
module clcd_front
    import clcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_row,
    input  wire logic [5:0] i_column,
    input  wire logic       i_end_of_string,
    input  wire logic       i_full,
    output logic            busy,
    output logic            o_push,
    output t_job            o_job
);

    localparam logic MODE_INIT = 1'b0;
    localparam logic MODE_EOS  = 1'b1;

    logic              r_active, n_active;
    logic              r_mode,   n_mode;
    logic [STEP_W-1:0] r_step,   n_step;
    logic              accept;
    logic              newline;
    logic [5:0]        col_sat;

    assign busy    = r_active | i_full;
    assign accept  = start & ~busy;
    assign newline = (i_char_code == CHAR_NEWLINE);
    assign col_sat = (i_column > COL_MAX) ? COL_MAX : i_column;

    always_comb begin
        n_active = r_active;
        n_mode   = r_mode;
        n_step   = r_step;
        o_push   = 1'b0;
        o_job    = init_job(r_step);
        if (r_active) begin
            o_push = ~i_full;
            if (r_mode == MODE_EOS) begin
                o_job = byte_job(1'b0, INS_SET_DDRAM, 16'd0, 1'b1);
            end
            if (~i_full) begin
                if (r_mode == MODE_EOS || r_step == INIT_LAST_STEP) begin
                    n_active = 1'b0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
        end else if (accept) begin
            o_push = 1'b1;
            unique case (i_command)
                CMD_INIT: begin
                    o_job    = init_job(STEP_W'(0));
                    n_active = 1'b1;
                    n_mode   = MODE_INIT;
                    n_step   = STEP_W'(1);
                end
                CMD_CHAR: begin
                    if (newline) begin
                        o_job = byte_job(1'b0, INS_SET_DDRAM | INS_ROW1, 16'd0,
                                         ~i_end_of_string);
                    end else begin
                        o_job = byte_job(1'b1, i_char_code, 16'd0, ~i_end_of_string);
                    end
                    n_active = i_end_of_string;
                    n_mode   = MODE_EOS;
                end
                CMD_CURSOR: begin
                    o_job = byte_job(1'b0, INS_SET_DDRAM | (i_row ? INS_ROW1 : 8'h00)
                                     | {2'b00, col_sat}, 16'd0, 1'b1);
                end
                default: begin
                    o_job = byte_job(1'b0, INS_CLEAR, 16'd0, 1'b1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_mode   <= MODE_INIT;
            r_step   <= '0;
        end else begin
            r_active <= n_active;
            r_mode   <= n_mode;
            r_step   <= n_step;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/clcd_fifo.sv @@
// Short job queue between intake and pin sequencer.
// Depends on clcd_pkg.
`default_nettype none
module clcd_fifo
    import clcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty,
    output logic      o_full
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/clcd_back.sv @@
// Pin sequencer: expands the head job into one segment per cycle.
// Depends on clcd_pkg.
`default_nettype none
module clcd_back
    import clcd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_job       i_job,
    input  wire logic  i_empty,
    output logic       o_pop,
    output logic       o_strobe,
    output logic       o_reg_select,
    output logic       o_enable,
    output logic [3:0] o_nibble,
    output logic [15:0] o_hold_us,
    output logic       o_last
);

    logic [1:0]  r_seg, n_seg;
    logic [1:0]  last_idx;
    logic        seg_last;
    logic        r_strobe;
    logic        r_rs, r_e, r_last;
    logic [3:0]  r_nib;
    logic [15:0] r_hold;
    logic        seg_e;
    logic [3:0]  seg_nib;

    always_comb begin
        unique case (i_job.kind)
            JOB_WAIT:   last_idx = 2'd0;
            JOB_NIBBLE: last_idx = 2'd1;
            default:    last_idx = 2'd3;
        endcase
    end

    assign seg_last = (r_seg == last_idx);
    assign o_pop    = ~i_empty & seg_last;
    assign n_seg    = seg_last ? 2'd0 : r_seg + 2'd1;
    assign seg_e    = (i_job.kind != JOB_WAIT) & ~r_seg[0];
    // bytes go high nibble first
    assign seg_nib  = (i_job.kind == JOB_BYTE && !r_seg[1]) ? i_job.value[7:4]
                                                             : i_job.value[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ~i_empty;
            if (!i_empty) r_seg <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_empty) begin
            r_rs   <= i_job.rs;
            r_e    <= seg_e;
            r_nib  <= seg_nib;
            r_hold <= seg_last ? i_job.final_hold : E_PULSE_US;
            r_last <= i_job.last & seg_last;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_reg_select = r_rs;
    assign o_enable     = r_e;
    assign o_nibble     = r_nib;
    assign o_hold_us    = r_hold;
    assign o_last       = r_last;

endmodule
`default_nettype wire

@@ hw/rtl/char_lcd_4bit_interface.sv @@
// Top level of the 4-bit character LCD interface.
// Depends on clcd_pkg, clcd_front, clcd_fifo, clcd_back.
//
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// request   | start / busy         | i_command i_char_code i_row i_column
//           |                      | i_end_of_string
// segment   | o_strobe (one cycle) | o_reg_select o_enable o_nibble o_hold_us
//           |                      | o_last
//
// One segment word leaves per cycle while jobs are queued; the back-end segment
// counter steps through the segments of the head job.
// The front end pushes one job per cycle into a 4-deep queue unless it is full;
// busy is high while it still pushes jobs of a request or the queue is full.
// Reset is synchronous, active low, and clears the queue and sequencers.
// The receiver cannot stall: each segment word shows for exactly one cycle.
`default_nettype none
module char_lcd_4bit_interface
    import clcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_row,
    input  wire logic [5:0]  i_column,
    input  wire logic        i_end_of_string,
    output logic             o_strobe,
    output logic             o_reg_select,
    output logic             o_enable,
    output logic [3:0]       o_nibble,
    output logic [15:0]      o_hold_us,
    output logic             o_last
);

    // job path between intake and sequencer
    logic push, pop, q_empty, q_full;
    t_job push_job, head_job;

    // intake: classify requests, expand init and end of string into jobs
    clcd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_command       (i_command),
        .i_char_code     (i_char_code),
        .i_row           (i_row),
        .i_column        (i_column),
        .i_end_of_string (i_end_of_string),
        .i_full          (q_full),
        .busy            (busy),
        .o_push          (push),
        .o_job           (push_job)
    );

    clcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // sequencer: one registered segment word per cycle
    clcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_reg_select (o_reg_select),
        .o_enable     (o_enable),
        .o_nibble     (o_nibble),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

@@ hw/rtl/clcd_checker.sv @@
// Port-level checks on the segment stream of the LCD interface.
// Depends on char_lcd_4bit_interface_defines.svh; bound to the top level.
`default_nettype none
`include "char_lcd_4bit_interface_defines.svh"
module clcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_strobe,
    input wire logic        o_enable,
    input wire logic [3:0]  o_nibble,
    input wire logic [15:0] o_hold_us
,   input wire logic        o_last
);

    // E-high pulses are always the short width
    `CLCD_ASSERT(a_pulse_width, o_strobe && o_enable |-> o_hold_us == 16'd5, "E pulse width")
    // E high is followed at once by E low on the same nibble
    `CLCD_ASSERT(a_pulse_pair, o_strobe && o_enable |=> o_strobe && !o_enable && $stable(o_nibble), "E pulse not closed")
    // a request never ends with E high
    `CLCD_ASSERT(a_last_low, o_strobe && o_last |-> !o_enable, "last segment with E high")
    // reset silences the stream
    `CLCD_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_strobe, "segment after reset")

endmodule

bind char_lcd_4bit_interface clcd_checker u_clcd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_strobe  (o_strobe),
    .o_enable  (o_enable),
    .o_nibble  (o_nibble),
    .o_hold_us (o_hold_us),
    .o_last    (o_last)
);
`default_nettype wire
